/* rtl/fvdi_pkg.sv */
package fvdi_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned VERTEX_ENTRIES_DEF  = 128;
	localparam int unsigned BYTE_MAX            = 255;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} vertex_t;

	typedef struct packed {
		logic hit;
		logic [7:0] idx;
	} hit_t;

	function automatic logic is_nan(input word_t w);
		is_nan = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
	endfunction

	function automatic logic comp_eq(input word_t p, input word_t q);
		if (is_nan(p) || is_nan(q)) begin
			comp_eq = 1'b0;
		end else if (((p | q) & 32'h7FFF_FFFF) == 32'd0) begin
			comp_eq = 1'b1;
		end else begin
			comp_eq = (p == q);
		end
	endfunction

endpackage

/* rtl/fvdi_pal_cell.sv */
module fvdi_pal_cell import fvdi_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic  clk,
	input  logic  wr,
	input  word_t wdata,
	input  word_t key,
	input  logic  used,
	input  hit_t  hin,
	output hit_t  hout
);
	word_t ent_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q <= wdata;
		end
	end

	// stored words are distinct, so at most one cell matches and the row ORs together
	always_comb begin
		hout = hin;
		if (used && ent_q == key) begin
			hout.hit = 1'b1;
			hout.idx = hin.idx | 8'(IDX);
		end
	end
endmodule

/* rtl/fvdi_vtx_cell.sv */
module fvdi_vtx_cell import fvdi_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic    clk,
	input  logic    wr,
	input  vertex_t wdata,
	input  vertex_t key,
	input  logic    used,
	input  hit_t    hin,
	output hit_t    hout
);
	vertex_t ent_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q <= wdata;
		end
	end

	// stored vertices never compare equal to each other, so at most one cell matches
	always_comb begin
		hout = hin;
		if (used && comp_eq(ent_q.x, key.x) && comp_eq(ent_q.y, key.y)
				&& comp_eq(ent_q.z, key.z)) begin
			hout.hit = 1'b1;
			hout.idx = hin.idx | 8'(IDX);
		end
	end
endmodule

/* rtl/face_vertex_dedup_indexer.sv */
// A face goes through the idle, vertex and output states: the surface word is matched
// against every palette cell at once in the accept cycle, then vertices a, b and c
// go through the row of vertex cells one after another, so a vertex can match one
// stored by the vertex before it, and the output state moves the result into the
// output register. Only then is the block idle again and able to take the next
// face; a result still waiting in the output register holds the block in its
// output state, so it stalls the input as well.
module face_vertex_dedup_indexer import fvdi_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
	parameter int unsigned VERTEX_ENTRIES  = VERTEX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        new_fragment,
	input  logic [31:0] surface_word,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] c_x,
	input  logic [31:0] c_y,
	input  logic [31:0] c_z,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  surface_index,
	output logic [6:0]  index_a,
	output logic [6:0]  index_b,
	output logic [6:0]  index_c,
	output logic        palette_full,
	output logic        vertices_full,
	output logic [7:0]  vertex_total
);
	localparam int PW = $clog2(PALETTE_ENTRIES + 1);
	localparam int VW = $clog2(VERTEX_ENTRIES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_VTX  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    k_q;
	logic [PW-1:0] pal_used_q;
	logic [VW-1:0] vtx_used_q;
	vertex_t       v_q [3];
	logic [6:0]    idx_q [3];
	logic          vfull_q;
	logic [7:0]    surf_q;
	logic          pfull_q;

	logic in_acc, out_acc, out_load;
	assign out_acc  = out_valid && !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_acc);

	hit_t ph [PALETTE_ENTRIES+1];
	hit_t vh [VERTEX_ENTRIES+1];
	assign ph[0] = '0;
	assign vh[0] = '0;

	logic    pal_new, pal_wr;
	logic    vtx_wr;
	vertex_t key;
	assign pal_new = in_acc && !ph[PALETTE_ENTRIES].hit;
	assign pal_wr  = pal_new && (pal_used_q < PW'(PALETTE_ENTRIES));
	assign key     = v_q[k_q];
	assign vtx_wr  = (state_q == ST_VTX) && !vh[VERTEX_ENTRIES].hit
		&& (vtx_used_q < VW'(VERTEX_ENTRIES));

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_pal
		fvdi_pal_cell #(.IDX(i)) u_cell (
			.clk(clk), .wr(pal_wr && pal_used_q == PW'(i)), .wdata(surface_word),
			.key(surface_word), .used(pal_used_q > PW'(i)),
			.hin(ph[i]), .hout(ph[i+1])
		);
	end

	for (genvar i = 0; i < VERTEX_ENTRIES; i++) begin : g_vtx
		fvdi_vtx_cell #(.IDX(i)) u_cell (
			.clk(clk), .wr(vtx_wr && vtx_used_q == VW'(i)), .wdata(key),
			.key(key), .used(vtx_used_q > VW'(i)),
			.hin(vh[i]), .hout(vh[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q[0] <= '{a_x, a_y, a_z};
			v_q[1] <= '{b_x, b_y, b_z};
			v_q[2] <= '{c_x, c_y, c_z};
			surf_q <= pal_new ? (pal_wr ? 8'(pal_used_q) : 8'd0)
				: ph[PALETTE_ENTRIES].idx;
			pfull_q <= pal_new && !pal_wr;
		end
		if (state_q == ST_VTX) begin
			if (vh[VERTEX_ENTRIES].hit) begin
				idx_q[k_q] <= vh[VERTEX_ENTRIES].idx[6:0];
			end else if (vtx_wr) begin
				idx_q[k_q] <= 7'(vtx_used_q);
			end else begin
				idx_q[k_q] <= 7'd0;
			end
		end
		if (out_load) begin
			surface_index <= surf_q;
			index_a       <= idx_q[0];
			index_b       <= idx_q[1];
			index_c       <= idx_q[2];
			palette_full  <= pfull_q;
			vertices_full <= vfull_q;
			vertex_total  <= 8'(vtx_used_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			k_q        <= '0;
			pal_used_q <= '0;
			vtx_used_q <= '0;
			vfull_q    <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_acc) begin
				out_valid <= 1'b0;
			end
			if (pal_wr) begin
				pal_used_q <= pal_used_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_VTX;
						k_q     <= '0;
						vfull_q <= 1'b0;
						if (new_fragment) begin
							vtx_used_q <= '0;
						end
					end
				end
				ST_VTX: begin
					if (vtx_wr) begin
						vtx_used_q <= vtx_used_q + 1'b1;
					end
					if (!vh[VERTEX_ENTRIES].hit && !vtx_wr) begin
						vfull_q <= 1'b1;
					end
					if (k_q == 2'd2) begin
						state_q <= ST_OUT;
						k_q     <= '0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_used_q <= VW'(VERTEX_ENTRIES)) else $error("vertex count overrun");
	a_pal_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pal_used_q <= PW'(PALETTE_ENTRIES)) else $error("palette count overrun");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("accept while busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |=> out_valid) else $error("result lost");
endmodule

/* bench/face_vertex_dedup_indexer_tb.sv */
`timescale 1ns / 1ps

module face_vertex_dedup_indexer_tb;
	import fvdi_pkg::*;

	localparam int unsigned PAL_N = PALETTE_ENTRIES_DEF;
	localparam int unsigned VTX_N = VERTEX_ENTRIES_DEF;
	localparam int unsigned RANDOM_FACES = 1700;
	localparam int unsigned QUIET_LIMIT = 20000;

	typedef struct packed {
		logic    nf;
		word_t   surf;
		vertex_t va;
		vertex_t vb;
		vertex_t vc;
	} face_t;

	typedef struct packed {
		logic [7:0] surf_idx;
		logic [6:0] ia;
		logic [6:0] ib;
		logic [6:0] ic;
		logic       pal_full;
		logic       vtx_full;
		logic [7:0] total;
	} face_idx_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic new_fragment;
	logic [31:0] surface_word;
	logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic out_valid;
	logic out_stall;
	logic [7:0] surface_index;
	logic [6:0] index_a, index_b, index_c;
	logic palette_full, vertices_full;
	logic [7:0] vertex_total;

	face_vertex_dedup_indexer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.new_fragment(new_fragment), .surface_word(surface_word),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.surface_index(surface_index),
		.index_a(index_a), .index_b(index_b), .index_c(index_c),
		.palette_full(palette_full), .vertices_full(vertices_full),
		.vertex_total(vertex_total)
	);

	// predictor state
	word_t     pal_words[PAL_N];
	int        pal_count;
	vertex_t   vtx_rows[VTX_N];
	int        vtx_count;

	face_t     pending_faces[$];
	face_idx_t expected_idx[$];
	int        errors;
	bit        all_sent;
	bit        calm;
	bit        long_hold;
	bit        hold_done;
	int        quiet;

	function automatic logic float_eq(word_t p, word_t q);
		logic pn, qn;
		pn = (p[30:23] == 8'hFF) && (p[22:0] != 0);
		qn = (q[30:23] == 8'hFF) && (q[22:0] != 0);
		if (pn || qn) return 1'b0;
		if (p[30:0] == 0 && q[30:0] == 0) return 1'b1;
		return p == q;
	endfunction

	function automatic int find_or_add_vertex(vertex_t v, ref logic full);
		for (int i = 0; i < vtx_count; i++)
			if (float_eq(vtx_rows[i].x, v.x) && float_eq(vtx_rows[i].y, v.y) &&
					float_eq(vtx_rows[i].z, v.z))
				return i;
		if (vtx_count >= VTX_N) begin
			full = 1'b1;
			return 0;
		end
		vtx_rows[vtx_count] = v;
		vtx_count++;
		return vtx_count - 1;
	endfunction

	function automatic face_idx_t index_face(face_t f);
		face_idx_t r;
		int s;
		logic vf;
		int ia, ib, ic;
		bit hit;
		r = '0;
		vf = 1'b0;
		hit = 0;
		s = 0;
		if (f.nf) vtx_count = 0;
		for (int i = 0; i < pal_count; i++)
			if (!hit && pal_words[i] == f.surf) begin
				s = i;
				hit = 1;
			end
		if (!hit) begin
			if (pal_count >= PAL_N) begin
				r.pal_full = 1'b1;
				s = 0;
			end else begin
				pal_words[pal_count] = f.surf;
				s = pal_count;
				pal_count++;
			end
		end
		ia = find_or_add_vertex(f.va, vf);
		ib = find_or_add_vertex(f.vb, vf);
		ic = find_or_add_vertex(f.vc, vf);
		r.surf_idx = s[7:0];
		r.ia = ia[6:0];
		r.ib = ib[6:0];
		r.ic = ic[6:0];
		r.vtx_full = vf;
		r.total = vtx_count[7:0];
		return r;
	endfunction

	// coordinates drawn from a small pool so repeats and signed zeros are common
	function automatic word_t pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7FC0_0000 | $urandom_range(0, 3);
			3: return $urandom();
			4: return 32'h7F80_0000;
			default: return 32'h3F80_0000 + $urandom_range(0, 5);
		endcase
	endfunction

	function automatic vertex_t pick_vertex();
		vertex_t v;
		v.x = pick_coord();
		v.y = pick_coord();
		v.z = pick_coord();
		return v;
	endfunction

	function automatic face_t random_face(int surf_span);
		face_t f;
		f.nf = ($urandom_range(0, 39) == 0);
		f.surf = ($urandom_range(0, 7) == 0) ? $urandom() :
			32'hA500_0000 + $urandom_range(0, surf_span);
		f.va = pick_vertex();
		f.vb = ($urandom_range(0, 3) == 0) ? f.va : pick_vertex();
		f.vc = ($urandom_range(0, 3) == 0) ? f.vb : pick_vertex();
		return f;
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		face_t f;
		vertex_t v;
		arst_n = 0;
		errors = 0;
		all_sent = 0;
		calm = 0;
		long_hold = 0;
		pal_count = 0;
		vtx_count = 0;
		// directed: extremes, zeros of both signs, NaN, self-matching faces
		f = '0;
		f.nf = 1;
		pending_faces = {pending_faces, f};
		f.nf = 0;
		f.surf = '1;
		f.va = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		f.vb = '1;
		f.vc = '1;
		pending_faces = {pending_faces, f};
		f.surf = 32'h5555_5555;
		f.va = {32'h7FC0_0000, 32'h0, 32'h0};
		f.vb = f.va;
		f.vc = {32'h7F80_0000, 32'hFF80_0000, 32'hAAAA_AAAA};
		pending_faces = {pending_faces, f};
		f.surf = 32'hAAAA_AAAA;
		f.va = {32'h5555_5555, 32'h5555_5555, 32'h5555_5555};
		f.vb = f.vc;
		f.vc = f.va;
		pending_faces = {pending_faces, f};
		f.nf = 1;
		f.surf = 32'h0;
		pending_faces = {pending_faces, f};
		// fill the vertex table past full within one fragment
		for (int i = 0; i < 50; i++) begin
			f.nf = (i == 0);
			f.surf = 32'h1000 + i[0];
			v = {32'h4000_0000, i[31:0], 32'd1};
			f.va = v;
			v.z = 32'd2;
			f.vb = v;
			v.z = 32'd3;
			f.vc = v;
			pending_faces = {pending_faces, f};
		end
		// random faces; palette span grows to drive it past full late in the run
		for (int i = 0; i < RANDOM_FACES; i++)
			pending_faces = {pending_faces, random_face(i < 800 ? 40 : 400)};
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	task automatic f_drive(face_t f);
		in_valid <= 1;
		new_fragment <= f.nf;
		surface_word <= f.surf;
		{a_x, a_y, a_z} <= f.va;
		{b_x, b_y, b_z} <= f.vb;
		{c_x, c_y, c_z} <= f.vc;
	endtask

	// sender
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap <= 0;
			{new_fragment, surface_word, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <= '0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid && pending_faces.size() == 0) all_sent <= 1;
			if (in_gap > 0) begin
				in_valid <= 0;
				in_gap <= in_gap - 1;
			end else if (!calm && !long_hold && $urandom_range(0, 9) == 0) begin
				in_valid <= 0;
				in_gap <= $urandom_range(0, 10);
			end else if (pending_faces.size() > 0) begin
				f_drive(pending_faces.pop_front());
			end else begin
				in_valid <= 0;
			end
		end
	end

	// predict on input acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			face_t f;
			f = {new_fragment, surface_word, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
			expected_idx = {expected_idx, index_face(f)};
		end
	end

	// receiver
	int out_gap;
	int hold_cnt;
	int out_beats;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			out_gap <= 0;
			hold_cnt <= 0;
			out_beats <= 0;
			calm <= 0;
			long_hold <= 0;
			hold_done <= 0;
		end else begin
			if (out_valid && !out_stall) out_beats <= out_beats + 1;
			if (out_beats > 1400) calm <= 1;
			if (out_beats == 300 && hold_cnt == 0 && !hold_done) begin
				long_hold <= 1;
				hold_done <= 1;
				hold_cnt <= 200;
				out_stall <= 1;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				if (hold_cnt == 1) out_stall <= 0;
			end else if (calm) begin
				out_stall <= 0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= (out_gap > 1);
			end else if ($urandom_range(0, 9) == 0) begin
				out_gap <= $urandom_range(1, 11);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
			if (hold_cnt == 1) long_hold <= 0;
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			face_idx_t e;
			if (expected_idx.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_idx.pop_front();
				if (surface_index !== e.surf_idx) begin
					$error("surface_index exp %0d got %0d", e.surf_idx, surface_index);
					errors++;
				end
				if (index_a !== e.ia) begin
					$error("index_a exp %0d got %0d", e.ia, index_a);
					errors++;
				end
				if (index_b !== e.ib) begin
					$error("index_b exp %0d got %0d", e.ib, index_b);
					errors++;
				end
				if (index_c !== e.ic) begin
					$error("index_c exp %0d got %0d", e.ic, index_c);
					errors++;
				end
				if (palette_full !== e.pal_full) begin
					$error("palette_full exp %0b got %0b", e.pal_full, palette_full);
					errors++;
				end
				if (vertices_full !== e.vtx_full) begin
					$error("vertices_full exp %0b got %0b", e.vtx_full, vertices_full);
					errors++;
				end
				if (vertex_total !== e.total) begin
					$error("vertex_total exp %0d got %0d", e.total, vertex_total);
					errors++;
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_cnt > 0)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (arst_n && quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		while (!(all_sent && expected_idx.size() == 0)) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_idx.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/fvdi_pkg.sv
rtl/fvdi_pal_cell.sv
rtl/fvdi_vtx_cell.sv
rtl/face_vertex_dedup_indexer.sv
bench/face_vertex_dedup_indexer_tb.sv
